/* hdl/route_request_id_cache_unit_defines.svh */
// Assertion macros for the route request id cache.
// Used by the slot cell and the top level; no other dependency.
`ifndef ROUTE_REQUEST_ID_CACHE_UNIT_DEFINES_SVH
`define ROUTE_REQUEST_ID_CACHE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RRIC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RRIC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRIC_ASSERT(label, clk, rst_n, prop, msg)
`define RRIC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* hdl/rric_pkg.sv */
// Package for the route request id cache: sizes and the shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rric_pkg;
  localparam int TABLE_SLOTS    = 16;
  localparam int IDS_PER_SOURCE = 8;
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int POS_W  = (IDS_PER_SOURCE > 1) ? $clog2(IDS_PER_SOURCE) : 1;
  localparam int FILL_W = $clog2(IDS_PER_SOURCE + 1);
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

  // token passed down the row of slot cells
  typedef struct packed {
    logic              valid;
    logic [31:0]       addr;
    logic [15:0]       id;
    logic [31:0]       now;
    logic              found;      // a cell holds this source
    logic [SLOT_W-1:0] found_idx;
    logic              seen;       // id already in that cell's ring
    logic              free_ok;    // a free cell seen so far
    logic [SLOT_W-1:0] free_idx;
    logic [31:0]       old_time;   // oldest creation time so far
    logic [SLOT_W-1:0] old_idx;
    logic              old_free;   // oldest cell is free
  } scan_t;

  // decision broadcast to every cell at the end of the scan
  typedef struct packed {
    logic              wr;         // write happens this cycle
    logic              claim;      // claim slot (else append)
    logic [SLOT_W-1:0] idx;
    logic [31:0]       addr;
    logic [15:0]       id;
    logic [31:0]       now;
  } upd_t;
endpackage
`default_nettype wire

/* hdl/rric_if.sv */
// Valid/ready channel interfaces for requests and results.
// Imports rric_pkg; the slot index field of the result is a fixed 4 bits wide.
`timescale 1ns / 1ps
`default_nettype none
interface rric_req_if import rric_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [15:0] request_id;
  logic [31:0] now_time;
  modport source (output valid, source_address, request_id, now_time, input ready);
  modport sink (input valid, source_address, request_id, now_time, output ready);
endinterface

interface rric_res_if ();
  logic       valid;
  logic       ready;
  logic       already_seen;
  logic [3:0] slot_used;
  logic       evicted;
  logic       rejected;
  modport source (output valid, already_seen, slot_used, evicted, rejected, input ready);
  modport sink (input valid, already_seen, slot_used, evicted, rejected, output ready);
endinterface
`default_nettype wire

/* hdl/rric_cell.sv */
// One table slot: source, creation time and id ring, plus its scan step.
// Depends on rric_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "route_request_id_cache_unit_defines.svh"
module rric_cell import rric_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] my_idx,
  input  wire scan_t             scan_in,
  output scan_t                  scan_r,
  input  wire upd_t              upd
);
  logic [31:0]       src_r;
  logic [31:0]       created_r;
  logic [15:0]       ring_r [IDS_PER_SOURCE];
  logic [POS_W-1:0]  head_r, tail_r;
  logic [FILL_W-1:0] fill_r;
  logic              hit;
  logic              mine;
  scan_t             scan_nxt;

  // ring lookup over independent entries, in position order
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < IDS_PER_SOURCE; k++) begin
      if ((FILL_W'(k) < fill_r) &&
          (ring_r[POS_W'((32'(head_r) + 32'(k)) % IDS_PER_SOURCE)] == scan_in.id))
        hit = 1'b1;
    end
  end

  // scan step: fold this slot into the travelling token
  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.found && src_r == scan_in.addr) begin
      scan_nxt.found     = 1'b1;
      scan_nxt.found_idx = my_idx;
      scan_nxt.seen      = hit;
    end
    if (!scan_in.free_ok && src_r == 32'd0) begin
      scan_nxt.free_ok  = 1'b1;
      scan_nxt.free_idx = my_idx;
    end
    if (my_idx == '0 || created_r < scan_in.old_time) begin
      scan_nxt.old_time = created_r;
      scan_nxt.old_idx  = my_idx;
      scan_nxt.old_free = (src_r == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) scan_r <= '0;
    else        scan_r <= scan_nxt;
  end

  assign mine = upd.wr && upd.idx == my_idx;

  // slot update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else if (mine) begin
      if (upd.claim) begin
        src_r  <= upd.addr;
        head_r <= '0;
        tail_r <= POS_W'(1 % IDS_PER_SOURCE);
        fill_r <= FILL_W'(1);
      end else begin
        tail_r <= POS_W'((32'(tail_r) + 32'd1) % IDS_PER_SOURCE);
        if (32'(fill_r) < IDS_PER_SOURCE) fill_r <= fill_r + FILL_W'(1);
        else head_r <= POS_W'((32'(head_r) + 32'd1) % IDS_PER_SOURCE);
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (mine) begin
      if (upd.claim) begin
        created_r <= upd.now;
        ring_r[0] <= upd.id;
      end else begin
        ring_r[tail_r] <= upd.id;
      end
    end
  end

  `RRIC_ASSERT(a_fill_max, clk, rst_n, 32'(fill_r) <= IDS_PER_SOURCE, "ring fill overflow")
  `RRIC_ASSERT(a_free_empty, clk, rst_n, (src_r == 32'd0) |-> (fill_r == '0), "free slot holds ids")
  `RRIC_ASSERT(a_used_fill, clk, rst_n, (src_r != 32'd0) |-> (fill_r != '0), "used slot empty")
endmodule
`default_nettype wire

/* hdl/route_request_id_cache_unit.sv */
// Route request id cache: duplicate suppression for route requests.
// One request in, one result out, over valid/ready channels.
// A request enters a row of TABLE_SLOTS slot cells; a token carrying the
// request moves one cell per cycle, gathering match, free and oldest slot.
// After the last cell the decision is made and written back to the chosen
// slot as the result register is loaded. An accepted request is registered
// in the head register, passes through the register of each cell in turn,
// and its result is then registered. Requests are handled one at a time: a
// new one is taken only once the result has been read and the unit is idle.
// A zero source address is rejected with no change to the table; its result
// is valid in the cycle after acceptance, and it skips the scan state.
// Reset (rst_n low, synchronous) frees every slot; no clearing pass.
// While the receiver stalls, the result is held in the output register and
// no new request is accepted until it is taken.
// Depends on rric_pkg, rric_if, rric_cell and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "route_request_id_cache_unit_defines.svh"
module route_request_id_cache_unit import rric_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  rric_req_if.sink   in_req,
  rric_res_if.source out_res
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  scan_t             head_r, head_nxt;
  scan_t             chain [TABLE_SLOTS+1];
  upd_t              upd;
  logic [CNT_W-1:0]  in_use_r;
  logic              seen_r, evict_r, rej_r;
  logic [SLOT_W-1:0] used_r;
  scan_t             fin;
  logic              fin_v;

  assign in_req.ready = (state_r == ST_IDLE);
  wire accept = in_req.valid && in_req.ready;

  // token enters the row once per accepted request with a nonzero source address
  always_comb begin
    head_nxt = '0;
    if (accept && in_req.source_address != 32'd0) begin
      head_nxt.valid = 1'b1;
      head_nxt.addr  = in_req.source_address;
      head_nxt.id    = in_req.request_id;
      head_nxt.now   = in_req.now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) head_r <= '0;
    else        head_r <= head_nxt;
  end

  assign chain[0] = head_r;
  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    rric_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(SLOT_W'(g)),
      .scan_in(chain[g]), .scan_r(chain[g+1]), .upd(upd)
    );
  end

  assign fin   = chain[TABLE_SLOTS];
  assign fin_v = fin.valid;

  // decision at the end of the row
  logic              dec_claim, dec_evict, dec_cnt;
  logic [SLOT_W-1:0] dec_idx;
  always_comb begin
    dec_claim = 1'b1;
    dec_evict = 1'b0;
    dec_cnt   = 1'b0;
    dec_idx   = fin.old_idx;
    priority if (fin.found) begin
      dec_claim = 1'b0;
      dec_idx   = fin.found_idx;
    end else if (32'(in_use_r) < TABLE_SLOTS && fin.free_ok) begin
      dec_idx = fin.free_idx;
      dec_cnt = 1'b1;
    end else begin
      if (fin.old_free && 32'(in_use_r) < TABLE_SLOTS) dec_cnt = 1'b1;
      else dec_evict = 1'b1;
    end
  end

  assign upd.wr    = fin_v && !(fin.found && fin.seen);
  assign upd.claim = dec_claim;
  assign upd.idx   = dec_idx;
  assign upd.addr  = fin.addr;
  assign upd.id    = fin.id;
  assign upd.now   = fin.now;

  // control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = (in_req.source_address == 32'd0) ? ST_OUT : ST_SCAN;
      ST_SCAN: if (fin_v) state_nxt = ST_OUT;
      ST_OUT:  if (out_res.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      in_use_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin_v && !fin.found && dec_cnt) in_use_r <= in_use_r + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept && in_req.source_address == 32'd0) begin
      seen_r <= 1'b0; used_r <= '0; evict_r <= 1'b0; rej_r <= 1'b1;
    end else if (fin_v) begin
      seen_r  <= fin.found && fin.seen;
      used_r  <= dec_idx;
      evict_r <= !fin.found && dec_evict;
      rej_r   <= 1'b0;
    end
  end

  assign out_res.valid        = (state_r == ST_OUT);
  assign out_res.already_seen = seen_r;
  assign out_res.slot_used    = 4'(used_r);
  assign out_res.evicted      = evict_r;
  assign out_res.rejected     = rej_r;

  `RRIC_ASSERT(a_cnt_max, clk, rst_n, 32'(in_use_r) <= TABLE_SLOTS, "slot count overflow")
  `RRIC_ASSERT(a_fin_scan, clk, rst_n, fin_v |-> (state_r == ST_SCAN), "token outside scan")
  `RRIC_ASSERT(a_out_hold, clk, rst_n, (out_res.valid && !out_res.ready) |=> out_res.valid, "result dropped")
endmodule
`default_nettype wire
